[src/fcf_pkg.sv]
package fcf_pkg;

   localparam int MAX_INPUTS_DEF  = 64;
   localparam int MAX_OUTPUTS_DEF = 64;
   localparam int IDX_W           = 12;   // covers up to 4096 inputs
   localparam logic [6:0] COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      REQ_WEIGHT = 2'd0,
      REQ_BIAS   = 2'd1,
      REQ_ELEM   = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   typedef enum logic {
      REG_INPUT_COUNT  = 1'b0,
      REG_OUTPUT_COUNT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   // one element travelling down the chain
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [IDX_W-1:0]  idx;
      logic signed [15:0] x;
   } tok_type;

   typedef struct packed {
      logic              en;
      logic [5:0]        row;
      logic [5:0]        col;
      logic signed [15:0] value;
   } wr_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         sat_add = s[31:0];
      end
   endfunction

endpackage

[src/fcf_req_if.sv]
interface fcf_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [5:0]        row;
   logic [5:0]        col;
   logic signed [15:0] value;
   logic              last;

   modport source (output valid, req_type, row, col, value, last, input ready);
   modport sink   (input valid, req_type, row, col, value, last, output ready);
endinterface

[src/fcf_rsp_if.sv]
interface fcf_rsp_if;
   logic              valid;
   logic              ready;
   logic [5:0]        out_index;
   logic signed [31:0] out_value;
   logic              length_error;
   logic              run_end;

   modport source (output valid, out_index, out_value, length_error, run_end, input ready);
   modport sink   (input valid, out_index, out_value, length_error, run_end, output ready);
endinterface

[src/fcf_cell.sv]
module fcf_cell #(
   parameter int MAX_INPUTS = fcf_pkg::MAX_INPUTS_DEF,
   parameter int CELL_ID    = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  fcf_pkg::tok_type    tok_in,
   output fcf_pkg::tok_type    tok_out,
   input  fcf_pkg::wr_type     wwr,
   input  fcf_pkg::wr_type     bwr,
   input  logic                shift,
   input  logic signed [31:0]  res_in,
   output logic signed [31:0]  res_out,
   output logic                done
);
   import fcf_pkg::*;

   localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

   logic signed [15:0] wmem [MAX_INPUTS];
   logic signed [15:0] w_q;
   logic signed [15:0] bias_ff;
   tok_type            tok_ff;
   logic               b_valid_ff, b_first_ff, b_last_ff;
   logic signed [31:0] prod_ff;
   logic signed [31:0] acc_ff, acc_in;
   logic               c_last_ff;
   logic signed [31:0] res_ff;
   logic               done_ff;
   logic [31:0]        col_wide;
   logic               w_hit, b_hit;

   assign col_wide = 32'(wwr.col);
   assign w_hit = wwr.en && (32'(wwr.row) == CELL_ID) && (col_wide < MAX_INPUTS);
   assign b_hit = bwr.en && (32'(bwr.row) == CELL_ID);

   always_ff @(posedge clock) begin
      if (w_hit) wmem[col_wide[IW-1:0]] <= wwr.value;
      if (tok_in.valid) w_q <= wmem[tok_in.idx[IW-1:0]];
      if (b_hit) bias_ff <= bwr.value;
   end

   // hop register to the neighbor, plus multiply stage
   always_ff @(posedge clock) begin
      b_first_ff <= tok_ff.first;
      b_last_ff  <= tok_ff.last;
      if (tok_ff.valid) prod_ff <= w_q * tok_ff.x;
      if (reset) begin
         tok_ff.valid <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         tok_ff       <= tok_in;
         b_valid_ff   <= tok_ff.valid;
      end
   end

   assign acc_in = sat_add(b_first_ff ? 32'sd0 : acc_ff, prod_ff);

   always_ff @(posedge clock) begin
      if (b_valid_ff) acc_ff <= acc_in;
      if (c_last_ff) begin
         res_ff <= sat_add(acc_ff, {{8{bias_ff[15]}}, bias_ff, 8'h00});
      end else if (shift) begin
         res_ff <= res_in;
      end
      if (reset) begin
         c_last_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         c_last_ff <= b_valid_ff && b_last_ff;
         done_ff   <= c_last_ff;
      end
   end

   assign tok_out = tok_ff;
   assign res_out = res_ff;
   assign done    = done_ff;
endmodule

[src/fully_connected_forward.sv]
// Fully connected forward pass on a chain of MAX_OUTPUTS multiply-accumulate cells.
// Results appear once the last element has crossed the whole chain; they then leave
// one per cycle when rsp is ready.
// A vector passes through collection, the element stream walking the whole chain, then draining;
// no new request, load or element, is taken until the last result has left.
// Reset (synchronous, active high) clears control state; counts return to 64.
module fully_connected_forward #(
   parameter int MAX_INPUTS  = fcf_pkg::MAX_INPUTS_DEF,
   parameter int MAX_OUTPUTS = fcf_pkg::MAX_OUTPUTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fcf_req_if.sink     req,
   fcf_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fcf_pkg::*;

   localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int CW = $clog2(MAX_INPUTS + 1);

   // ---- configuration registers ----
   logic [6:0] in_cnt_ff, out_cnt_ff;
   logic       csr_wr;
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= COUNT_RESET;
         out_cnt_ff <= COUNT_RESET;
      end else if (csr_wr) begin
         unique case (reg_index_type'(paddr[2]))
            REG_INPUT_COUNT:  in_cnt_ff  <= pwdata[6:0];
            REG_OUTPUT_COUNT: out_cnt_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end
   assign prdata = {25'd0, paddr[2] ? out_cnt_ff : in_cnt_ff};

   // effective counts, clamped to 1..max
   int nin_i, nout_i;
   always_comb begin
      if (in_cnt_ff == 7'd0)             nin_i = 1;
      else if (int'(in_cnt_ff) > MAX_INPUTS) nin_i = MAX_INPUTS;
      else                               nin_i = int'(in_cnt_ff);
      if (out_cnt_ff == 7'd0)             nout_i = 1;
      else if (int'(out_cnt_ff) > MAX_OUTPUTS) nout_i = MAX_OUTPUTS;
      else                                nout_i = int'(out_cnt_ff);
   end

   // ---- control ----
   state_type        state_ff;
   logic [CW-1:0]    cnt_ff;      // elements collected
   logic             ovf_ff;      // too many elements
   logic             err_ff;      // pending error transaction
   logic [CW-1:0]    j_ff;        // element being issued
   logic             iss_ff;      // still issuing elements
   logic [5:0]       oidx_ff;
   logic signed [15:0] vbuf [MAX_INPUTS];
   logic signed [15:0] vbuf_q;
   logic             feed_valid_ff, feed_first_ff, feed_last_ff;
   logic [IW-1:0]    feed_idx_ff;

   logic req_acc, rsp_acc, room, last_issue, rd_en, is_end;
   logic [CW-1:0] cnt_next;
   logic          bad;
   wr_type        wwr, bwr;

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_acc    = req.valid && req.ready;
   assign rsp_acc    = rsp.valid && rsp.ready;
   assign room       = (int'(cnt_ff) < MAX_INPUTS);
   assign cnt_next   = room ? cnt_ff + CW'(1) : cnt_ff;
   assign bad        = ovf_ff || !room || (int'(cnt_next) != nin_i);
   assign rd_en      = (state_ff == ST_RUN) && iss_ff;
   assign last_issue = rd_en && (int'(j_ff) + 1 == nin_i);
   assign is_end     = (int'(oidx_ff) + 1 == nout_i);

   assign wwr.en    = req_acc && (req_code_type'(req.req_type) == REQ_WEIGHT);
   assign wwr.row   = req.row;
   assign wwr.col   = req.col;
   assign wwr.value = req.value;
   assign bwr.en    = req_acc && (req_code_type'(req.req_type) == REQ_BIAS)
                      && (int'(req.row) < MAX_OUTPUTS);
   assign bwr.row   = req.row;
   assign bwr.col   = req.col;
   assign bwr.value = req.value;

   // vector buffer: one write on element arrival, one read per issued element
   always_ff @(posedge clock) begin
      if (req_acc && req_code_type'(req.req_type) == REQ_ELEM && room)
         vbuf[cnt_ff[IW-1:0]] <= req.value;
      if (rd_en) vbuf_q <= vbuf[j_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      feed_first_ff <= (j_ff == '0);
      feed_last_ff  <= last_issue;
      feed_idx_ff   <= j_ff[IW-1:0];
      if (reset) feed_valid_ff <= 1'b0;
      else       feed_valid_ff <= rd_en;
   end

   // ---- cell chain ----
   tok_type            tok_chain [MAX_OUTPUTS+1];
   logic signed [31:0] res_chain [MAX_OUTPUTS+1];
   logic               done_v    [MAX_OUTPUTS];
   logic               shift;

   assign tok_chain[0].valid = feed_valid_ff;
   assign tok_chain[0].first = feed_first_ff;
   assign tok_chain[0].last  = feed_last_ff;
   assign tok_chain[0].idx   = IDX_W'(feed_idx_ff);
   assign tok_chain[0].x     = vbuf_q;
   assign res_chain[MAX_OUTPUTS] = 32'sd0;
   assign shift = rsp_acc && !err_ff;

   for (genvar k = 0; k < MAX_OUTPUTS; k++) begin : g_cell
      fcf_cell #(.MAX_INPUTS(MAX_INPUTS), .CELL_ID(k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_chain[k]),
         .tok_out (tok_chain[k+1]),
         .wwr     (wwr),
         .bwr     (bwr),
         .shift   (shift),
         .res_in  (res_chain[k+1]),
         .res_out (res_chain[k]),
         .done    (done_v[k])
      );
   end

   // the far cell finishes last; every result is in place then
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         err_ff   <= 1'b0;
         j_ff     <= '0;
         iss_ff   <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_code_type'(req.req_type) == REQ_ELEM) begin
                  if (req.last) begin
                     cnt_ff  <= '0;
                     ovf_ff  <= 1'b0;
                     oidx_ff <= '0;
                     if (bad) begin
                        err_ff   <= 1'b1;
                        state_ff <= ST_OUT;
                     end else begin
                        j_ff     <= '0;
                        iss_ff   <= 1'b1;
                        state_ff <= ST_RUN;
                     end
                  end else begin
                     cnt_ff <= cnt_next;
                     if (!room) ovf_ff <= 1'b1;
                  end
               end
            end
            ST_RUN: begin
               if (rd_en) j_ff <= j_ff + CW'(1);
               if (last_issue) iss_ff <= 1'b0;
               if (done_v[MAX_OUTPUTS-1]) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_acc) begin
                  if (err_ff || is_end) begin
                     err_ff   <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     oidx_ff <= oidx_ff + 6'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---- result channel ----
   assign rsp.valid        = (state_ff == ST_OUT);
   assign rsp.out_index    = err_ff ? 6'd0 : oidx_ff;
   assign rsp.out_value    = err_ff ? 32'sd0 : res_chain[0];
   assign rsp.length_error = err_ff;
   assign rsp.run_end      = err_ff || is_end;
endmodule

[src/fcf_checker.sv]
module fcf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_out_index,
   input logic [31:0] rsp_out_value,
   input logic        rsp_length_error,
   input logic        rsp_run_end
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while results pending");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |->
         rsp_run_end && rsp_out_index == 6'd0 && rsp_out_value == 32'd0)
      else $error("malformed error transaction");

   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_end |=>
         rsp_valid && rsp_out_index == $past(rsp_out_index) + 6'd1)
      else $error("result index out of order");

   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind fully_connected_forward fcf_checker u_fcf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_out_index    (rsp.out_index),
   .rsp_out_value    (rsp.out_value),
   .rsp_length_error (rsp.length_error),
   .rsp_run_end      (rsp.run_end)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import fcf_pkg::*;

   // expected / observed output transaction
   typedef struct {
      logic [5:0]         idx;
      logic signed [31:0] val;
      logic               err;
      logic               fin;
   } fc_result_type;

   // Scoreboard: holds a private copy of the layer (stores, vector buffer,
   // counts) and predicts the results of every accepted request.
   class fc_scoreboard;
      logic signed [15:0] weight[64][64];
      logic signed [15:0] bias[64];
      logic signed [15:0] vec[64];
      int                 n_elem;
      bit                 overrun;
      int                 in_cnt;
      int                 out_cnt;
      fc_result_type      pending[$];
      int                 errors;

      function new();
         n_elem  = 0;
         overrun = 0;
         in_cnt  = 64;
         out_cnt = 64;
         errors  = 0;
      endfunction

      function void set_count(reg_index_type r, logic [6:0] v);
         if (r == REG_INPUT_COUNT) in_cnt = v;
         else out_cnt = v;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // note one accepted request, queue whatever results it causes
      function void note_request(logic [1:0] t, logic [5:0] row, logic [5:0] col,
                                 logic signed [15:0] value, logic last);
         int            nin;
         int            nout;
         longint        acc;
         fc_result_type r;
         if (t == REQ_WEIGHT) begin
            weight[row][col] = value;
         end else if (t == REQ_BIAS) begin
            bias[row] = value;
         end else if (t == REQ_ELEM) begin
            if (n_elem < 64) begin
               vec[n_elem] = value;
               n_elem++;
            end else begin
               overrun = 1;
            end
            if (last) begin
               nin  = (in_cnt < 1) ? 1 : (in_cnt > 64) ? 64 : in_cnt;
               nout = (out_cnt < 1) ? 1 : (out_cnt > 64) ? 64 : out_cnt;
               if (overrun || n_elem != nin) begin
                  r.idx = 0; r.val = 0; r.err = 1; r.fin = 1;
                  pending.push_back(r);
               end else begin
                  for (int i = 0; i < nout; i++) begin
                     acc = 0;
                     for (int j = 0; j < nin; j++)
                        acc = sat32(acc + longint'(weight[i][j]) * longint'(vec[j]));
                     acc = sat32(acc + longint'(bias[i]) * 256);
                     r.idx = i; r.val = acc[31:0]; r.err = 0; r.fin = (i == nout - 1);
                     pending.push_back(r);
                  end
               end
               n_elem  = 0;
               overrun = 0;
            end
         end
      endfunction

      function void check_result(fc_result_type got);
         fc_result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result idx=%0d val=%0d err=%0d end=%0d",
                        got.idx, got.val, got.err, got.fin);
            return;
         end
         want = pending.pop_front();
         if (got.idx !== want.idx || got.val !== want.val || got.err !== want.err ||
             got.fin !== want.fin) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp idx=%0d val=%0d err=%0d end=%0d / got idx=%0d val=%0d err=%0d end=%0d",
                        want.idx, want.val, want.err, want.fin,
                        got.idx, got.val, got.err, got.fin);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   fcf_req_if req_if();
   fcf_rsp_if rsp_if();

   fully_connected_forward i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if.sink),
      .rsp     (rsp_if.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   fc_scoreboard sb = new();

   int tx_idle_pct = 36;       // sender gap chance per transaction
   int rx_idle_pct = 72;       // receiver stall chance per cycle
   bit hold_req    = 0;        // ask the ready process for a long stall
   int hold_left   = 0;
   int cycles      = 0;
   int n_sent      = 0;        // counts loads and elements

   initial begin
      req_if.valid    = 0;
      req_if.req_type = REQ_NOP;
      req_if.row      = 0;
      req_if.col      = 0;
      req_if.value    = 0;
      req_if.last     = 0;
      rsp_if.ready    = 0;
   end

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stalls, plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else if (hold_req) begin
         hold_req  = 0;
         hold_left = 600;
         rsp_if.ready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // monitor: results are checked before the same-edge request is noted
   always @(posedge clock) begin
      fc_result_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.idx = rsp_if.out_index;
            got.val = rsp_if.out_value;
            got.err = rsp_if.length_error;
            got.fin = rsp_if.run_end;
            sb.check_result(got);
         end
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.req_type, req_if.row, req_if.col,
                            req_if.value, req_if.last);
      end
   end

   // mostly random words, with the extremes and small values mixed in
   function automatic logic [15:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h8000;
      if (r < 20) return 16'h7fff;
      if (r < 35) return 16'($urandom_range(0, 511) - 256);
      return 16'($urandom);
   endfunction

   // one request transaction; returns at the accepting edge
   task automatic send(req_code_type t, logic [5:0] row, logic [5:0] col,
                       logic [15:0] value, logic last);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_if.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid    <= 1;
      req_if.req_type <= t;
      req_if.row      <= row;
      req_if.col      <= col;
      req_if.value    <= value;
      req_if.last     <= last;
      do @(posedge clock); while (!req_if.ready);
      if (t != REQ_NOP) n_sent++;
   endtask

   task automatic send_vector(int len);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 99) < 5)
            send(REQ_NOP, 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
         send(REQ_ELEM, 6'($urandom), 6'($urandom), pick_value(), k == len - 1);
      end
   endtask

   // one edge first so the monitor has noted the last accepted request
   task automatic wait_drained();
      req_if.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type r, logic [6:0] v);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= {r, 2'b00};
      pwdata  <= {25'd0, v};
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      sb.set_count(r, v);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
   endtask

   // block idle, pipeline flushed, then both counts
   task automatic set_counts(logic [6:0] nin, logic [6:0] nout);
      wait_drained();
      repeat (200) @(posedge clock);
      csr_write(REG_INPUT_COUNT, nin);
      csr_write(REG_OUTPUT_COUNT, nout);
   endtask

   // random traffic: mostly well-formed vectors, some broken ones and loads
   task automatic run_random(int n_items, int mode, bit pressure);
      int nin;
      int stop_at;
      int r;
      int len;
      nin     = (sb.in_cnt < 1) ? 1 : (sb.in_cnt > 64) ? 64 : sb.in_cnt;
      stop_at = n_sent + n_items;
      case (mode)
         0: begin tx_idle_pct = 36; rx_idle_pct = 72; end
         1: begin tx_idle_pct = 72; rx_idle_pct = 36; end
         default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      if (pressure) begin
         hold_req = 1;          // receiver blocks while vectors keep coming
         send_vector(nin);
         send_vector(nin);
         send_vector(nin);
      end
      while (n_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            send_vector(nin);
         end else if (r < 78) begin
            do len = $urandom_range(1, 12); while (len == nin);
            send_vector(len);
         end else if (r < 88) begin
            send(REQ_WEIGHT, 6'($urandom), 6'($urandom), pick_value(), 1'($urandom));
         end else if (r < 93) begin
            send(REQ_BIAS, 6'($urandom), 6'($urandom), pick_value(), 1'($urandom));
         end else if (r < 96) begin
            send(REQ_NOP, 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
         end else begin
            wait_drained();    // sender pauses until all results are back
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill the 8 x 8 corner and its biases; counts stay inside it
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++)
            send(REQ_WEIGHT, 6'(i), 6'(j), pick_value(), 1'($urandom));
         send(REQ_BIAS, 6'(i), 6'($urandom), pick_value(), 1'($urandom));
      end

      // directed: saturation both ways, last flag on loads, nop, bad lengths
      set_counts(7'd2, 7'd3);
      send(REQ_WEIGHT, 6'd0, 6'd0, 16'h8000, 1'b1);
      send(REQ_WEIGHT, 6'd0, 6'd1, 16'h8000, 1'b0);
      send(REQ_WEIGHT, 6'd1, 6'd0, 16'h7fff, 1'b0);
      send(REQ_WEIGHT, 6'd1, 6'd1, 16'h7fff, 1'b1);
      send(REQ_WEIGHT, 6'd2, 6'd0, 16'h0001, 1'b0);
      send(REQ_WEIGHT, 6'd2, 6'd1, 16'hffff, 1'b0);
      send(REQ_BIAS, 6'd0, 6'd63, 16'h7fff, 1'b1);
      send(REQ_BIAS, 6'd1, 6'd0, 16'h8000, 1'b0);
      send(REQ_BIAS, 6'd2, 6'd0, 16'h0000, 1'b0);
      send(REQ_NOP, 6'h3f, 6'h3f, 16'hffff, 1'b1);
      send(REQ_ELEM, 6'd0, 6'd0, 16'h8000, 1'b0);   // +max positive sum
      send(REQ_ELEM, 6'h3f, 6'h3f, 16'h8000, 1'b1);
      send(REQ_ELEM, 6'd0, 6'd0, 16'h7fff, 1'b0);   // extreme elements of opposite sign
      send(REQ_ELEM, 6'd0, 6'd0, 16'h8000, 1'b1);
      send(REQ_ELEM, 6'd0, 6'd0, 16'h0100, 1'b1);   // too short
      send(REQ_ELEM, 6'd0, 6'd0, 16'h0100, 1'b0);   // too long
      send(REQ_ELEM, 6'd0, 6'd0, 16'h0100, 1'b0);
      send(REQ_ELEM, 6'd0, 6'd0, 16'h0100, 1'b1);
      wait_drained();
      send_vector(66);                              // overrun

      // random phases: small sizes, zero counts clamp to one
      run_random(30, 0, 0);
      set_counts(7'd0, 7'd0);                       // clamps to one
      run_random(20, 1, 0);
      set_counts(7'd5, 7'd8);
      run_random(30, 2, 1);
      for (int m = 0; m < 3; m++) begin
         set_counts(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
         run_random(15, m, 0);
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
